// ----- hw/rtl/tlvd_pkg.sv -----
// ----------------------------------------------------------------------------
// TLV deframer package
// Parse phases and the result word layout shared by the deframer modules.
// ----------------------------------------------------------------------------
package tlvd_pkg;

	localparam int unsigned TypeW = 16;
	localparam int unsigned ByteW = 8;
	localparam int unsigned LenW  = 16;

	typedef enum logic [2:0] {
		PH_TYPE_LO = 3'd0,
		PH_TYPE_HI = 3'd1,
		PH_LEN_LO  = 3'd2,
		PH_LEN_HI  = 3'd3,
		PH_VALUE   = 3'd4
	} tlvd_phase_t;

	typedef struct packed {
		logic [TypeW-1:0] item_type;
		logic [ByteW-1:0] value_byte;
		logic             is_first;
		logic             is_last;
		logic             is_empty;
		logic             truncated;
	} tlvd_result_t;

endpackage

// ----- hw/rtl/tlvd_parse.sv -----
// ----------------------------------------------------------------------------
// TLV deframer parser
// Header/value phase tracking and result formation, one byte per step.
// ----------------------------------------------------------------------------
module tlvd_parse
	import tlvd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [ByteW-1:0]    data_byte,
	input  logic                end_of_payload,
	output logic                res_valid,
	output tlvd_result_t        res
);

	tlvd_phase_t      phase_q, phase_d;
	logic [TypeW-1:0] type_q, type_d;
	logic [ByteW-1:0] len_lo_q, len_lo_d;
	logic [LenW-1:0]  rem_q, rem_d;
	logic             first_q, first_d;
	logic [LenW-1:0]  len_full;
	logic [LenW-1:0]  rem_dec;

	assign len_full = {data_byte, len_lo_q};
	assign rem_dec  = rem_q - LenW'(1);

	// next state
	always_comb begin
		phase_d  = phase_q;
		type_d   = type_q;
		len_lo_d = len_lo_q;
		rem_d    = rem_q;
		first_d  = first_q;
		unique case (phase_q)
			PH_TYPE_HI: begin
				type_d  = {data_byte, type_q[ByteW-1:0]};
				phase_d = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				len_lo_d = data_byte;
				phase_d  = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				if (len_full == '0) begin
					phase_d = PH_TYPE_LO;
				end else begin
					rem_d   = len_full;
					first_d = 1'b1;
					phase_d = PH_VALUE;
				end
			end
			PH_VALUE: begin
				first_d = 1'b0;
				rem_d   = rem_dec;
				if (rem_dec == '0) begin
					phase_d = PH_TYPE_LO;
				end
			end
			default: begin
				type_d  = {type_q[TypeW-1:ByteW], data_byte};
				phase_d = PH_TYPE_HI;
			end
		endcase
		if (end_of_payload) begin
			phase_d = PH_TYPE_LO;
			first_d = 1'b1;
			rem_d   = '0;
		end
	end

	// result
	always_comb begin
		res_valid      = 1'b0;
		res.item_type  = type_q;
		res.value_byte = data_byte;
		res.is_first   = first_q;
		res.is_last    = 1'b0;
		res.is_empty   = 1'b0;
		res.truncated  = 1'b0;
		unique case (phase_q)
			PH_LEN_HI: begin
				res_valid      = (len_full == '0);
				res.value_byte = '0;
				res.is_first   = 1'b0;
				res.is_empty   = 1'b1;
			end
			PH_VALUE: begin
				res_valid     = 1'b1;
				res.is_last   = (rem_dec == '0);
				res.truncated = (rem_dec != '0) && end_of_payload;
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_TYPE_LO;
			type_q   <= '0;
			len_lo_q <= '0;
			rem_q    <= '0;
			first_q  <= 1'b1;
		end else if (step) begin
			phase_q  <= phase_d;
			type_q   <= type_d;
			len_lo_q <= len_lo_d;
			rem_q    <= rem_d;
			first_q  <= first_d;
		end
	end

endmodule

// ----- hw/rtl/tlv_stream_deframer_top.sv -----
// ----------------------------------------------------------------------------
// TLV stream deframer
// Splits a byte stream of type/length/value items into value words tagged
// with the item type and first/last/empty/truncated marks.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                          | tuser                   | tlast
//  s_*     | in  | [7:0] data_byte                | -                       | end_of_payload
//  m_*     | out | [15:0] item_type [23:16] value | [0] first [1] empty [2] trunc | is_last
//
// One word per cycle while the output does not stall; a word passes the input register,
// then the result register. Only an empty item's length-high byte gives a header result.
// Reset clears both stage valids and the parse state to a header start.
// A stalled result holds the result register; the input register still takes
// a word when empty and stalls only when both stages are full.
// ----------------------------------------------------------------------------
module tlv_stream_deframer_top
	import tlvd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [15:0] item_type, [23:16] value_byte
	output logic [2:0]  m_tuser,   // [0] is_first, [1] is_empty, [2] truncated
	output logic        m_tlast
);

	logic             v_s1;
	logic [ByteW-1:0] data_s1;
	logic             eop_s1;
	logic             out_v_q;
	tlvd_result_t     res_q;
	logic             adv;
	logic             step;
	logic             res_valid;
	tlvd_result_t     res;

	assign adv      = !out_v_q || m_tready;
	assign step     = v_s1 && adv;
	assign s_tready = !v_s1 || adv;

	tlvd_parse u_parse (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.data_byte      (data_s1),
		.end_of_payload (eop_s1),
		.res_valid      (res_valid),
		.res            (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1 <= s_tdata;
			eop_s1  <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= step && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {res_q.value_byte, res_q.item_type};
	assign m_tuser  = {res_q.truncated, res_q.is_empty, res_q.is_first};
	assign m_tlast  = res_q.is_last;

endmodule

// ----- hw/rtl/tlvd_checker.sv -----
// ----------------------------------------------------------------------------
// TLV deframer port checker
// Port-level checks on result marks and output stalls.
// ----------------------------------------------------------------------------
module tlvd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic [2:0]  m_tuser,
	input logic        m_tlast
);

	// an empty item carries no byte and no other mark
	a_empty_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |->
			m_tdata[23:16] == 8'h00 && !m_tuser[0] && !m_tuser[2] && !m_tlast)
		else $error("empty word carries data or marks");

	a_trunc_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |-> !m_tlast)
		else $error("truncated word marked last");

	a_stall_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=>
			$stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
		else $error("result changed while stalled");

endmodule

bind tlv_stream_deframer_top tlvd_checker u_tlvd_checker (.*);
